/* sv/tre_pkg.sv */
// Shared types and constants of the TGA run-length packet encoder.
// No dependencies; every other file of the block imports this package.
package tre_pkg;

   localparam int RAW_BUFFER_DEPTH = 128;
   localparam int RAW_IDX_W        = $clog2(RAW_BUFFER_DEPTH);
   localparam int RAW_ROWS         = RAW_BUFFER_DEPTH / 4;
   localparam int RAW_ROW_W        = $clog2(RAW_ROWS);
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W      = QUEUE_PTR_W + 1;

   localparam logic [6:0] PACKET_LIMIT = 7'd127;
   localparam logic [7:0] RUN_FLAG     = 8'b1000_0000;

   localparam logic [1:0] CSR_ROW_WIDTH    = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // One packet to be sent. A raw packet holds buf_cnt buffered pixels,
   // optionally followed by the pixel field as its tail.
   typedef struct packed {
      logic                 is_run;
      logic [RAW_IDX_W-1:0] buf_cnt;
      logic                 has_tail;
      logic [31:0]          pixel;
      logic [6:0]           run_len;
      logic                 final_pkt;
      logic                 last_item;
   } cmd_type;

   typedef struct packed {
      logic                 en;
      logic [RAW_IDX_W-1:0] addr;
      logic [31:0]          data;
   } buf_wr_type;

endpackage

/* sv/tre_cmd_queue.sv */
// Short command queue between the encoder front and back.
// Depends on tre_pkg; takes up to two commands and gives one per cycle while pop is high.
module tre_cmd_queue
   import tre_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_n,
   input  cmd_type                push_first,
   input  cmd_type                push_second,
   input  logic                   pop,
   output cmd_type                head,
   output logic [QUEUE_CNT_W-1:0] count
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic [QUEUE_PTR_W-1:0] tail_next;

   assign tail_next = tail_ff + 1'b1;
   assign head      = entry_ff[head_ff];
   assign count     = count_ff;

   always_comb begin
      head_in  = head_ff + QUEUE_PTR_W'(pop);
      tail_in  = tail_ff + QUEUE_PTR_W'(push_n);
      count_in = count_ff + QUEUE_CNT_W'(push_n) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      if (push_n != 2'd0) begin
         entry_ff[tail_ff] <= push_first;
      end
      if (push_n == 2'd2) begin
         entry_ff[tail_next] <= push_second;
      end
   end

endmodule

/* sv/tre_front.sv */
// Encoder front: accepts pixels, tracks runs, raw fill and row position,
// writes raw pixels and queues packet commands. Depends on tre_pkg.
module tre_front
   import tre_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,
   input  logic [7:0]             req_alpha,
   input  logic                   csr_write_enable,
   input  logic [1:0]             csr_index,
   input  logic [15:0]            csr_write_data,
   input  logic [QUEUE_CNT_W-1:0] q_count,
   input  logic                   raw_done,
   output logic [1:0]             push_n,
   output cmd_type                push_first,
   output cmd_type                push_second,
   output buf_wr_type             buf_wr
);

   typedef enum logic [1:0] {M_IDLE, M_PEND, M_RUN, M_RAW} mode_type;

   mode_type             mode_ff, mode_in;
   logic [31:0]          held_ff, held_in;
   logic [RAW_IDX_W-1:0] fill_ff, fill_in;
   logic [6:0]           run_ff, run_in;
   logic [15:0]          col_ff, col_in;
   logic [15:0]          row_ff, row_in;
   logic [15:0]          row_width_ff, image_height_ff;
   logic [1:0]           raw_out_ff, raw_out_in;

   logic        accept, eq, last_col, last_row;
   logic [31:0] pix;
   logic [16:0] eff_w, eff_h;
   logic        a_v, b_v;
   cmd_type     cmd_a, cmd_b;

   assign pix      = {req_alpha, req_blue, req_green, req_red};
   assign eq       = (held_ff == pix);
   assign eff_w    = {row_width_ff == 16'd0, row_width_ff};
   assign eff_h    = {image_height_ff == 16'd0, image_height_ff};
   assign last_col = ({1'b0, col_ff} + 17'd1) >= eff_w;
   assign last_row = ({1'b0, row_ff} + 17'd1) >= eff_h;

   // Stall while a raw packet drains (one shared buffer) or the queue lacks room.
   assign req_stall = (raw_out_ff != 2'd0) ||
                      (q_count > QUEUE_CNT_W'(QUEUE_DEPTH - 2));
   assign accept    = req_valid && !req_stall;

   always_comb begin
      mode_in = mode_ff;
      held_in = held_ff;
      fill_in = fill_ff;
      run_in  = run_ff;
      buf_wr  = '{en: 1'b0, addr: fill_ff, data: held_ff};
      a_v     = 1'b0;
      b_v     = 1'b0;
      cmd_a   = '{is_run: 1'b1, buf_cnt: fill_ff, has_tail: 1'b0, pixel: held_ff,
                  run_len: run_ff, final_pkt: 1'b0, last_item: !last_col};
      cmd_b   = '{is_run: 1'b0, buf_cnt: '0, has_tail: 1'b1, pixel: pix,
                  run_len: run_ff, final_pkt: last_row, last_item: 1'b1};

      case (mode_ff)
         M_IDLE: begin
            held_in = pix;
            mode_in = M_PEND;
         end
         M_PEND: begin
            if (eq) begin
               run_in  = 7'd2;
               mode_in = M_RUN;
            end else begin
               buf_wr.en   = accept;
               buf_wr.addr = '0;
               fill_in     = RAW_IDX_W'(1);
               held_in     = pix;
               mode_in     = M_RAW;
            end
         end
         M_RUN: begin
            if (eq && run_ff < PACKET_LIMIT) begin
               run_in = run_ff + 7'd1;
            end else begin
               a_v     = 1'b1;
               held_in = pix;
               mode_in = M_PEND;
            end
         end
         M_RAW: begin
            if (!eq) begin
               buf_wr.en = accept;
               fill_in   = fill_ff + 1'b1;
               held_in   = pix;
               if (fill_in >= PACKET_LIMIT && !last_col) begin
                  a_v           = 1'b1;
                  cmd_a.is_run  = 1'b0;
                  cmd_a.buf_cnt = fill_in;
                  fill_in       = '0;
                  mode_in       = M_PEND;
               end
            end else begin
               a_v          = 1'b1;
               cmd_a.is_run = 1'b0;
               fill_in      = '0;
               run_in       = 7'd2;
               mode_in      = M_RUN;
            end
         end
         default: begin
            mode_in = M_IDLE;
         end
      endcase

      if (last_col) begin
         b_v           = (mode_in != M_IDLE);
         cmd_b.is_run  = (mode_in == M_RUN);
         cmd_b.buf_cnt = (mode_in == M_RAW) ? fill_in : '0;
         cmd_b.pixel   = held_in;
         cmd_b.run_len = run_in;
         mode_in       = M_IDLE;
         fill_in       = '0;
         run_in        = '0;
      end
   end

   always_comb begin
      push_n      = accept ? (2'(a_v) + 2'(b_v)) : 2'd0;
      push_first  = a_v ? cmd_a : cmd_b;
      push_second = cmd_b;
      raw_out_in  = raw_out_ff - 2'(raw_done);
      if (accept) begin
         raw_out_in = raw_out_in + 2'(a_v && !cmd_a.is_run) + 2'(b_v && !cmd_b.is_run);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= M_IDLE;
         held_ff         <= '0;
         fill_ff         <= '0;
         run_ff          <= '0;
         col_ff          <= '0;
         row_ff          <= '0;
         row_width_ff    <= 16'd1;
         image_height_ff <= 16'd1;
         raw_out_ff      <= '0;
      end else begin
         raw_out_ff <= raw_out_in;
         if (accept) begin
            mode_ff <= mode_in;
            held_ff <= held_in;
            fill_ff <= fill_in;
            run_ff  <= run_in;
            if (last_col) begin
               col_ff <= '0;
               row_ff <= last_row ? 16'd0 : row_ff + 16'd1;
            end else begin
               col_ff <= col_ff + 16'd1;
            end
         end
         if (csr_write_enable && csr_index == CSR_ROW_WIDTH) begin
            row_width_ff <= csr_write_data;
         end
         if (csr_write_enable && csr_index == CSR_IMAGE_HEIGHT) begin
            image_height_ff <= csr_write_data;
         end
      end
   end

endmodule

/* sv/tre_back.sv */
// Encoder back: holds the raw pixel buffer, takes queued packet commands
// and sends them as results of up to four pixels. Depends on tre_pkg.
module tre_back
   import tre_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  buf_wr_type             buf_wr,
   input  cmd_type                head,
   input  logic [QUEUE_CNT_W-1:0] q_count,
   output logic                   pop,
   output logic                   raw_done,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic                   rsp_has_header,
   output logic [7:0]             rsp_header_byte,
   output logic [2:0]             rsp_pixel_count,
   output logic [31:0]            rsp_pixel_slot_0,
   output logic [31:0]            rsp_pixel_slot_1,
   output logic [31:0]            rsp_pixel_slot_2,
   output logic [31:0]            rsp_pixel_slot_3,
   output logic                   rsp_packet_end,
   output logic                   rsp_image_end,
   output logic                   rsp_last_of_item
);

   typedef enum logic [1:0] {S_IDLE, S_RUN, S_READ, S_OUT} state_type;

   // Four lanes, one pixel of each row of four per lane.
   logic [31:0] buf_mem [4][RAW_ROWS];

   state_type            state_ff;
   cmd_type              cur_ff;
   logic [RAW_ROW_W-1:0] row_ff;
   logic [31:0]          rd_ff [4];
   logic                 valid_ff, has_hdr_ff, pend_ff, iend_ff, last_ff;
   logic [7:0]           hdr_ff;
   logic [2:0]           cnt_ff;
   logic [31:0]          slot_ff [4];

   logic        out_free;
   logic        emit;
   logic [7:0]  total, base, remain;
   logic [2:0]  cnt;
   logic        done;
   logic [31:0] slot [4];

   assign out_free = !valid_ff || !rsp_stall;
   assign emit     = out_free && ((state_ff == S_RUN) || (state_ff == S_OUT));
   assign total    = 8'(cur_ff.buf_cnt) + 8'(cur_ff.has_tail);
   assign base     = {1'b0, row_ff, 2'b00};
   assign remain   = total - base;
   assign done     = (remain <= 8'd4);
   assign cnt      = done ? remain[2:0] : 3'd4;
   assign pop      = (state_ff == S_IDLE) && (q_count != '0);
   assign raw_done = (state_ff == S_OUT) && out_free && done;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (3'(k) >= cnt) begin
            slot[k] = '0;
         end else if (8'(cur_ff.buf_cnt) > base + 8'(k)) begin
            slot[k] = rd_ff[k];
         end else begin
            slot[k] = cur_ff.pixel;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (buf_wr.en) begin
         buf_mem[buf_wr.addr[1:0]][buf_wr.addr[RAW_IDX_W-1:2]] <= buf_wr.data;
      end
      if (state_ff == S_READ) begin
         for (int k = 0; k < 4; k++) begin
            rd_ff[k] <= buf_mem[k][row_ff];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && !rsp_stall && !emit) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  cur_ff   <= head;
                  row_ff   <= '0;
                  state_ff <= head.is_run ? S_RUN : S_READ;
               end
            end
            S_RUN: begin
               if (out_free) begin
                  valid_ff   <= 1'b1;
                  has_hdr_ff <= 1'b1;
                  hdr_ff     <= RUN_FLAG | {1'b0, cur_ff.run_len - 7'd1};
                  cnt_ff     <= 3'd1;
                  slot_ff[0] <= cur_ff.pixel;
                  slot_ff[1] <= '0;
                  slot_ff[2] <= '0;
                  slot_ff[3] <= '0;
                  pend_ff    <= 1'b1;
                  iend_ff    <= cur_ff.final_pkt;
                  last_ff    <= cur_ff.last_item;
                  state_ff   <= S_IDLE;
               end
            end
            S_READ: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  valid_ff   <= 1'b1;
                  has_hdr_ff <= (row_ff == '0);
                  hdr_ff     <= (row_ff == '0) ? total - 8'd1 : 8'd0;
                  cnt_ff     <= cnt;
                  for (int k = 0; k < 4; k++) begin
                     slot_ff[k] <= slot[k];
                  end
                  pend_ff    <= done;
                  iend_ff    <= done && cur_ff.final_pkt;
                  last_ff    <= done && cur_ff.last_item;
                  row_ff     <= row_ff + 1'b1;
                  state_ff   <= done ? S_IDLE : S_READ;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_has_header   = has_hdr_ff;
   assign rsp_header_byte  = hdr_ff;
   assign rsp_pixel_count  = cnt_ff;
   assign rsp_pixel_slot_0 = slot_ff[0];
   assign rsp_pixel_slot_1 = slot_ff[1];
   assign rsp_pixel_slot_2 = slot_ff[2];
   assign rsp_pixel_slot_3 = slot_ff[3];
   assign rsp_packet_end   = pend_ff;
   assign rsp_image_end    = iend_ff;
   assign rsp_last_of_item = last_ff;

endmodule

/* sv/tga_rle_packet_encoder_top.sv */
// Top level of the TGA run-length packet encoder: front, queue and back.
// Depends on tre_pkg, tre_front, tre_cmd_queue and tre_back.
//
// Encodes a stream of 32-bit pixels, row by row, into TGA run packets (up to
// 127 equal pixels) and raw packets (up to 127 pixels, 128 at a row end).
// A pixel is taken every cycle unless the front stalls. The back end takes a
// run command and then sends its result; it takes a raw command and then,
// for each result of up to four pixels, reads a row of the four-lane raw
// buffer and sends it. While a raw packet is queued or being sent, or the
// queue has fewer than two free entries, the front holds off new pixels;
// the raw wait is there because the next raw packet reuses the same buffer.
// A row width or image height of zero means 65536.
module tga_rle_packet_encoder_top
   import tre_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [7:0]  req_alpha,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_has_header,
   output logic [7:0]  rsp_header_byte,
   output logic [2:0]  rsp_pixel_count,
   output logic [31:0] rsp_pixel_slot_0,
   output logic [31:0] rsp_pixel_slot_1,
   output logic [31:0] rsp_pixel_slot_2,
   output logic [31:0] rsp_pixel_slot_3,
   output logic        rsp_packet_end,
   output logic        rsp_image_end,
   output logic        rsp_last_of_item,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   logic [QUEUE_CNT_W-1:0] q_count;
   logic [1:0]             push_n;
   cmd_type                push_first, push_second, head;
   logic                   pop, raw_done;
   buf_wr_type             buf_wr;

   tre_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_red, .req_green, .req_blue,
      .req_alpha, .csr_write_enable, .csr_index, .csr_write_data, .q_count,
      .raw_done, .push_n, .push_first, .push_second, .buf_wr
   );

   tre_cmd_queue u_queue (
      .clock, .reset, .push_n, .push_first, .push_second, .pop, .head,
      .count (q_count)
   );

   tre_back u_back (
      .clock, .reset, .buf_wr, .head, .q_count, .pop, .raw_done, .rsp_stall,
      .rsp_valid, .rsp_has_header, .rsp_header_byte, .rsp_pixel_count,
      .rsp_pixel_slot_0, .rsp_pixel_slot_1, .rsp_pixel_slot_2, .rsp_pixel_slot_3,
      .rsp_packet_end, .rsp_image_end, .rsp_last_of_item
   );

   // An accepted pixel always finds room for the two commands it may queue.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> q_count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2))
      else $error("pixel accepted without queue room");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_end |-> rsp_packet_end)
      else $error("image end outside a packet end");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pixel_count != 3'd0 && rsp_pixel_count <= 3'd4)
      else $error("bad pixel count");

   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
